/* hdl/mva_pkg.sv */
// ----------------------------------------------------------------------------
// mva_pkg
// widths and shared types of the mixed voronoi corner area pipeline
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int COORD_W = 16;
  localparam int TAG_W   = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int LEN_W   = PROD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int RAD_W   = SQ_W + 2;
  localparam int NUM_W   = SQ_W + 1;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int AREA_W  = 35;
  localparam int DEN_W   = ROOT_W + 3;
  localparam int NLANES  = 3;
  localparam int IN_W    = TAG_W + 9 * COORD_W;
  localparam int OUT_W   = ((TAG_W + 3 * AREA_W + 7) / 8) * 8;
  localparam int USER_W  = 2;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             obt;
    logic             deg;
    logic [NLANES-1:0] neg;
  } side_t;

  typedef struct packed {
    side_t                        side;
    logic [NLANES-1:0][NUM_W-1:0] num;
  } sq_pay_t;

endpackage

/* hdl/mva_front.sv */
// ----------------------------------------------------------------------------
// mva_front
// edge vectors, dot and cross products, squared area and corner numerators
// ----------------------------------------------------------------------------
module mva_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  logic [mva_pkg::TAG_W-1:0]               in_tag,
  input  logic [2:0][mva_pkg::COORD_W-1:0]        pa,
  input  logic [2:0][mva_pkg::COORD_W-1:0]        pb,
  input  logic [2:0][mva_pkg::COORD_W-1:0]        pc,
  output logic                                    out_vld,
  output logic [mva_pkg::RAD_W-1:0]               out_rad,
  output mva_pkg::sq_pay_t                        out_pay
);

  localparam int DW = mva_pkg::DIFF_W;
  localparam int PW = mva_pkg::PROD_W;
  localparam int TW = mva_pkg::TAG_W;

  logic [4:0]          vld_r;
  logic [TW-1:0]       tag1_r, tag2_r, tag3_r, tag4_r;

  logic signed [DW-1:0] u_r [3], v_r [3], w_r [3];
  logic signed [DW-1:0] u_nxt [3], v_nxt [3], w_nxt [3];

  logic signed [PW-1:0] puv_r [3], puw_r [3], pvw_r [3], puu_r [3], pvv_r [3], pww_r [3];
  logic signed [PW-1:0] pca_r [3], pcb_r [3];
  logic signed [PW-1:0] puv_nxt [3], puw_nxt [3], pvw_nxt [3];
  logic signed [PW-1:0] puu_nxt [3], pvv_nxt [3], pww_nxt [3];
  logic signed [PW-1:0] pca_nxt [3], pcb_nxt [3];

  logic signed [mva_pkg::DOT_W-1:0]   da_r, db_r, dc_r, da_nxt, db_nxt, dc_nxt;
  logic signed [mva_pkg::DOT_W-1:0]   luu_s, lvv_s, lww_s;
  logic [mva_pkg::LEN_W-1:0]          luu_r, lvv_r, lww_r;
  logic signed [mva_pkg::CROSS_W-1:0] n_r [3], n_nxt [3];

  logic signed [mva_pkg::CROSS_W-1:0] nabs [3];
  logic [mva_pkg::SQ_W-1:0]           sq_r [3], sq_nxt [3];
  logic [mva_pkg::SQ_W-1:0]           ta_r, tb_r, tc_r;
  logic                               obt_r, deg_r;
  logic [2:0]                         neg_r;

  logic [mva_pkg::RAD_W-1:0]          rad_r;
  mva_pkg::sq_pay_t                   pay_r;

  // edge vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_nxt[k] = DW'($signed(pb[k])) - DW'($signed(pa[k]));
      v_nxt[k] = DW'($signed(pc[k])) - DW'($signed(pa[k]));
      w_nxt[k] = DW'($signed(pc[k])) - DW'($signed(pb[k]));
    end
  end

  // component products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      puv_nxt[k] = u_r[k] * v_r[k];
      puw_nxt[k] = u_r[k] * w_r[k];
      pvw_nxt[k] = v_r[k] * w_r[k];
      puu_nxt[k] = u_r[k] * u_r[k];
      pvv_nxt[k] = v_r[k] * v_r[k];
      pww_nxt[k] = w_r[k] * w_r[k];
    end
    pca_nxt[0] = u_r[1] * v_r[2];
    pcb_nxt[0] = u_r[2] * v_r[1];
    pca_nxt[1] = u_r[2] * v_r[0];
    pcb_nxt[1] = u_r[0] * v_r[2];
    pca_nxt[2] = u_r[0] * v_r[1];
    pcb_nxt[2] = u_r[1] * v_r[0];
  end

  // dot products, squared lengths, cross product
  always_comb begin
    da_nxt = mva_pkg::DOT_W'(puv_r[0]) + mva_pkg::DOT_W'(puv_r[1])
           + mva_pkg::DOT_W'(puv_r[2]);
    db_nxt = -(mva_pkg::DOT_W'(puw_r[0]) + mva_pkg::DOT_W'(puw_r[1])
           + mva_pkg::DOT_W'(puw_r[2]));
    dc_nxt = mva_pkg::DOT_W'(pvw_r[0]) + mva_pkg::DOT_W'(pvw_r[1])
           + mva_pkg::DOT_W'(pvw_r[2]);
    luu_s  = mva_pkg::DOT_W'(puu_r[0]) + mva_pkg::DOT_W'(puu_r[1])
           + mva_pkg::DOT_W'(puu_r[2]);
    lvv_s  = mva_pkg::DOT_W'(pvv_r[0]) + mva_pkg::DOT_W'(pvv_r[1])
           + mva_pkg::DOT_W'(pvv_r[2]);
    lww_s  = mva_pkg::DOT_W'(pww_r[0]) + mva_pkg::DOT_W'(pww_r[1])
           + mva_pkg::DOT_W'(pww_r[2]);
    for (int k = 0; k < 3; k++) begin
      n_nxt[k] = mva_pkg::CROSS_W'(pca_r[k]) - mva_pkg::CROSS_W'(pcb_r[k]);
    end
  end

  // cross magnitudes squared
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nabs[k]   = n_r[k][mva_pkg::CROSS_W-1] ? -n_r[k] : n_r[k];
      sq_nxt[k] = mva_pkg::SQ_W'(nabs[k][mva_pkg::MAG_W-1:0])
                * mva_pkg::SQ_W'(nabs[k][mva_pkg::MAG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= in_tag;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      w_r    <= w_nxt;

      tag2_r <= tag1_r;
      puv_r  <= puv_nxt;
      puw_r  <= puw_nxt;
      pvw_r  <= pvw_nxt;
      puu_r  <= puu_nxt;
      pvv_r  <= pvv_nxt;
      pww_r  <= pww_nxt;
      pca_r  <= pca_nxt;
      pcb_r  <= pcb_nxt;

      tag3_r <= tag2_r;
      da_r   <= da_nxt;
      db_r   <= db_nxt;
      dc_r   <= dc_nxt;
      luu_r  <= luu_s[mva_pkg::LEN_W-1:0];
      lvv_r  <= lvv_s[mva_pkg::LEN_W-1:0];
      lww_r  <= lww_s[mva_pkg::LEN_W-1:0];
      n_r    <= n_nxt;

      tag4_r <= tag3_r;
      sq_r   <= sq_nxt;
      ta_r   <= mva_pkg::SQ_W'(lww_r) * mva_pkg::SQ_W'(da_r[mva_pkg::LEN_W-1:0]);
      tb_r   <= mva_pkg::SQ_W'(lvv_r) * mva_pkg::SQ_W'(db_r[mva_pkg::LEN_W-1:0]);
      tc_r   <= mva_pkg::SQ_W'(luu_r) * mva_pkg::SQ_W'(dc_r[mva_pkg::LEN_W-1:0]);
      neg_r  <= {dc_r[mva_pkg::DOT_W-1], db_r[mva_pkg::DOT_W-1], da_r[mva_pkg::DOT_W-1]};
      obt_r  <= da_r[mva_pkg::DOT_W-1] | db_r[mva_pkg::DOT_W-1] | dc_r[mva_pkg::DOT_W-1];
      deg_r  <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

      rad_r          <= mva_pkg::RAD_W'(sq_r[0]) + mva_pkg::RAD_W'(sq_r[1])
                      + mva_pkg::RAD_W'(sq_r[2]);
      pay_r.side.tag <= tag4_r;
      pay_r.side.obt <= obt_r;
      pay_r.side.deg <= deg_r;
      pay_r.side.neg <= neg_r;
      pay_r.num[0]   <= mva_pkg::NUM_W'(tc_r) + mva_pkg::NUM_W'(tb_r);
      pay_r.num[1]   <= mva_pkg::NUM_W'(tc_r) + mva_pkg::NUM_W'(ta_r);
      pay_r.num[2]   <= mva_pkg::NUM_W'(tb_r) + mva_pkg::NUM_W'(ta_r);
    end
  end

  assign out_vld = vld_r[4];
  assign out_rad = rad_r;
  assign out_pay = pay_r;

endmodule

/* hdl/mva_sqrt.sv */
// ----------------------------------------------------------------------------
// mva_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module mva_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [mva_pkg::RAD_W-1:0]    in_rad,
  input  mva_pkg::sq_pay_t             in_pay,
  output logic                         out_vld,
  output logic [mva_pkg::ROOT_W-1:0]   out_root,
  output mva_pkg::sq_pay_t             out_pay
);

  localparam int NST = mva_pkg::ROOT_W;
  localparam int RW  = mva_pkg::ROOT_W;
  localparam int MW  = RW + 2;

  logic [NST-1:0]              vld_r;
  logic [mva_pkg::RAD_W-1:0]   rad_r  [NST];
  logic [MW-1:0]               rem_r  [NST];
  logic [RW-1:0]               root_r [NST];
  mva_pkg::sq_pay_t            pay_r  [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic [mva_pkg::RAD_W-1:0] rad_p;
    logic [MW-1:0]             rem_p, cur, trial;
    logic [RW-1:0]             root_p;
    mva_pkg::sq_pay_t          pay_p;

    if (k == 0) begin : g_first
      assign rad_p  = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign pay_p  = in_pay;
    end else begin : g_next
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign pay_p  = pay_r[k-1];
    end

    assign cur   = {rem_p[MW-3:0], rad_p[mva_pkg::RAD_W-1-2*k -: 2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_p;
        pay_r[k] <= pay_p;
        if (cur >= trial) begin
          rem_r[k]  <= cur - trial;
          root_r[k] <= {root_p[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur;
          root_r[k] <= {root_p[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_root = root_r[NST-1];
  assign out_pay  = pay_r[NST-1];

endmodule

/* hdl/mva_div_lane.sv */
// ----------------------------------------------------------------------------
// mva_div_lane
// one corner lane: pipelined restoring divide with saturation
// ----------------------------------------------------------------------------
module mva_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mva_pkg::NUM_W-1:0]    num,
  input  logic [mva_pkg::DEN_W-1:0]    den,
  output logic [mva_pkg::AREA_W-1:0]   quo
);

  localparam int NST = mva_pkg::AREA_W;
  localparam int DW  = mva_pkg::DEN_W;

  logic [DW-1:0]  rem_r [NST];
  logic [NST-1:0] q_r   [NST];
  logic [NST-1:0] lo_r  [NST];
  logic [DW-1:0]  den_r [NST];
  logic           ovf_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic [DW-1:0]  rem_p, den_p;
    logic [NST-1:0] q_p, lo_p;
    logic           ovf_p;
    logic [DW:0]    cur;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_p = DW'(num[mva_pkg::NUM_W-1:NST]);
      assign den_p = den;
      assign q_p   = '0;
      assign lo_p  = num[NST-1:0];
      assign ovf_p = DW'(num[mva_pkg::NUM_W-1:NST]) >= den;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign q_p   = q_r[k-1];
      assign lo_p  = lo_r[k-1];
      assign ovf_p = ovf_r[k-1];
    end

    assign cur = {rem_p, lo_p[NST-1-k]};
    assign ge  = cur >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(cur - {1'b0, den_p}) : cur[DW-1:0];
        q_r[k]   <= {q_p[NST-2:0], ge};
        lo_r[k]  <= lo_p;
        den_r[k] <= den_p;
        ovf_r[k] <= ovf_p;
      end
    end
  end

  assign quo = ovf_r[NST-1] ? mva_pkg::AREA_MAX : q_r[NST-1];

endmodule

/* hdl/mixed_voronoi_vertex_area.sv */
// ----------------------------------------------------------------------------
// mixed_voronoi_vertex_area
// mixed voronoi corner areas of one triangle per request
// ----------------------------------------------------------------------------
// One triangle request is taken every clock cycle while the output side keeps
// up; each result passes through 5 front stages, 35 square root stages, 35
// divider stages in three corner lanes and one output register. The square
// root and the three lane dividers resolve one result bit per stage, which
// sets the latency. A two-entry output register lets the block keep taking
// requests after out_tready falls, until its skid entry is filled.
module mixed_voronoi_vertex_area (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // face_tag, ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic [mva_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // face_tag_out, area_a, area_b, area_c, zero pad
  output logic [mva_pkg::OUT_W-1:0]     out_tdata,
  // is_obtuse, is_degenerate
  output logic [mva_pkg::USER_W-1:0]    out_tuser
);

  localparam int NDIV = mva_pkg::AREA_W;
  localparam int CW   = mva_pkg::COORD_W;
  localparam int TW   = mva_pkg::TAG_W;

  typedef struct packed {
    mva_pkg::side_t             side;
    logic [mva_pkg::ROOT_W-1:0] root;
  } dly_t;

  typedef struct packed {
    logic [mva_pkg::OUT_W-1:0]  data;
    logic [mva_pkg::USER_W-1:0] user;
  } res_t;

  logic                          en;
  logic [2:0][CW-1:0]            pa, pb, pc;
  logic                          f_vld, s_vld;
  logic [mva_pkg::RAD_W-1:0]     f_rad;
  mva_pkg::sq_pay_t              f_pay, s_pay;
  logic [mva_pkg::ROOT_W-1:0]    s_root;
  logic [mva_pkg::DEN_W-1:0]     den;
  logic [mva_pkg::AREA_W-1:0]    quo [mva_pkg::NLANES];
  logic [mva_pkg::AREA_W-1:0]    area [mva_pkg::NLANES];

  logic [NDIV-1:0]               dvld_r;
  dly_t                          dly_r [NDIV];
  dly_t                          d_in;
  res_t                          res;

  logic                          out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  res_t                          out_r, skid_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign pa[k] = in_tdata[TW + k*CW +: CW];
    assign pb[k] = in_tdata[TW + (3+k)*CW +: CW];
    assign pc[k] = in_tdata[TW + (6+k)*CW +: CW];
  end

  mva_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_tag  (in_tdata[TW-1:0]),
    .pa      (pa),
    .pb      (pb),
    .pc      (pc),
    .out_vld (f_vld),
    .out_rad (f_rad),
    .out_pay (f_pay)
  );

  mva_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_rad   (f_rad),
    .in_pay   (f_pay),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_pay  (s_pay)
  );

  assign den = {s_root, 3'b000};

  for (genvar l = 0; l < mva_pkg::NLANES; l++) begin : g_lane
    mva_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .num (s_pay.num[l]),
      .den (den),
      .quo (quo[l])
    );
  end

  // side information travels beside the lanes
  assign d_in.side = s_pay.side;
  assign d_in.root = s_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else if (en) begin
      dvld_r <= {dvld_r[NDIV-2:0], s_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= d_in;
      for (int k = 1; k < NDIV; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  // merge the lanes
  always_comb begin
    for (int l = 0; l < mva_pkg::NLANES; l++) begin
      if (dly_r[NDIV-1].side.deg) begin
        area[l] = '0;
      end else if (dly_r[NDIV-1].side.obt) begin
        area[l] = dly_r[NDIV-1].side.neg[l] ? (dly_r[NDIV-1].root >> 2)
                                             : (dly_r[NDIV-1].root >> 3);
      end else begin
        area[l] = quo[l];
      end
    end
    res.data = mva_pkg::OUT_W'({area[2], area[1], area[0], dly_r[NDIV-1].side.tag});
    res.user = {dly_r[NDIV-1].side.deg, dly_r[NDIV-1].side.obt};
  end

  // output register with skid entry
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_vld_r && !out_tready) begin
      if (dvld_r[NDIV-1] && en) begin
        skid_vld_nxt = 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_nxt  = 1'b1;
      skid_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = dvld_r[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_tready) begin
      if (dvld_r[NDIV-1] && en) begin
        skid_r <= res;
      end
    end else if (skid_vld_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.user;

  a_skid_implies_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without a waiting result");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.user[1]) |-> (out_r.data[TW + 3*mva_pkg::AREA_W - 1:TW] == '0))
    else $error("degenerate triangle with non-zero area");

  a_no_accept_full : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_vld_r && !out_tready) |=> skid_vld_r)
    else $error("skid entry lost while output stalled");

endmodule
